// ===== rtl/core/twma_pkg.sv =====
package twma_pkg;

   // window and register geometry
   localparam int WINDOW          = 5;
   localparam int VALUE_WIDTH_DEF = 20;
   localparam int LIMIT_WIDTH     = 20;
   localparam int REG_WIDTH       = 2 * LIMIT_WIDTH;
   localparam int REG_COUNT       = 6;
   localparam int CSR_INDEX_W     = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_WARN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CRIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HUMID_WARN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HUMID_CRIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GAS        = 3'd5;

   // channel codes
   localparam logic [1:0] CH_TEMP  = 2'd0;
   localparam logic [1:0] CH_HUMID = 2'd1;
   localparam logic [1:0] CH_LIGHT = 2'd2;
   localparam logic [1:0] CH_GAS   = 2'd3;

   typedef logic [REG_WIDTH-1:0] limit_reg_type;

   localparam limit_reg_type REG_RESET [REG_COUNT] = '{
      40'd2726299400, 40'd3670017000, 40'd6291459000,
      40'd8388610000, 40'd104857900,  40'd2097153000
   };

endpackage

// ===== rtl/core/trimmed_mean_window_alarm.sv =====
// Trimmed mean of a five-sample window with threshold alarm. Each item carries one
// sensor channel's window and a good-sample mask; the first maximum and first
// minimum of the good samples are dropped, the rest averaged (truncated toward
// zero) and checked against the channel's limits. The block takes one item per
// clock unless the result port stalls, with one stage each for
// the min/max search, the masked sum, the magnitude and reciprocal multiply for
// division by three, the quotient correction and sign, and the limit compares,
// whose register drives the result port. Two or four survivors divide by a shift.
// Stalls at the result port back up the stages one by one, so items keep flowing
// while any stage has a free slot. Limit registers are written via the csr port;
// the user must do so only while the block is idle; the block does not enforce it.
module trimmed_mean_window_alarm
   import twma_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_channel,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_0,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_1,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_2,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_3,
   input  logic signed [VALUE_WIDTH-1:0] req_sample_4,
   input  logic [WINDOW-1:0]             req_valid_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_out_channel,
   output logic signed [VALUE_WIDTH-1:0] rsp_average,
   output logic                          rsp_average_valid,
   output logic                          rsp_warn,
   output logic                          rsp_crit,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [REG_WIDTH-1:0]          csr_wdata
);

   localparam int SUM_W    = VALUE_WIDTH + 2;
   localparam int MAG_W    = VALUE_WIDTH + 1;
   localparam int SHIFT    = MAG_W + 2;
   localparam int RECIP_W  = MAG_W + 1;
   localparam int PROD_W   = MAG_W + RECIP_W;
   localparam int CMP_W    = ((VALUE_WIDTH > LIMIT_WIDTH) ? VALUE_WIDTH : LIMIT_WIDTH) + 1;
   localparam int IDX_W    = $clog2(WINDOW);
   localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'd3;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   function automatic logic signed [CMP_W-1:0] lim_ext(input logic [LIMIT_WIDTH-1:0] f);
      return CMP_W'(signed'(f));
   endfunction

   // limit registers
   limit_reg_type limit_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) limit_ff[i] <= REG_RESET[i];
      end else if (csr_write_en && (csr_index < CSR_INDEX_W'(REG_COUNT))) begin
         limit_ff[csr_index] <= csr_wdata;
      end
   end

   // handshake chain
   logic v_a_ff, v_b_ff, v_c_ff, v_d_ff, rsp_valid_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

   assign rdy_e     = !rsp_valid_ff || rsp_ready;
   assign rdy_d     = !v_d_ff || rdy_e;
   assign rdy_c     = !v_c_ff || rdy_d;
   assign rdy_b     = !v_b_ff || rdy_c;
   assign rdy_a     = !v_a_ff || rdy_b;
   assign req_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff       <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         v_d_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy_a) v_a_ff       <= req_valid;
         if (rdy_b) v_b_ff       <= v_a_ff;
         if (rdy_c) v_c_ff       <= v_b_ff;
         if (rdy_d) v_d_ff       <= v_c_ff;
         if (rdy_e) rsp_valid_ff <= v_d_ff;
      end
   end

   // stage a: first max / first min search, seeded from the first good sample
   logic signed [VALUE_WIDTH-1:0] samp [WINDOW];
   logic signed [VALUE_WIDTH-1:0] hi_val, lo_val;
   logic [IDX_W-1:0]              hi_idx, lo_idx;
   logic                          found;
   logic [WINDOW-1:0]             keep_in;

   assign samp[0] = req_sample_0;
   assign samp[1] = req_sample_1;
   assign samp[2] = req_sample_2;
   assign samp[3] = req_sample_3;
   assign samp[4] = req_sample_4;

   always_comb begin
      hi_val = '0;
      lo_val = '0;
      hi_idx = '0;
      lo_idx = '0;
      found  = 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
         if (req_valid_mask[k]) begin
            if (!found || samp[k] > hi_val) begin
               hi_val = samp[k];
               hi_idx = IDX_W'(k);
            end
            if (!found || samp[k] < lo_val) begin
               lo_val = samp[k];
               lo_idx = IDX_W'(k);
            end
            found = 1'b1;
         end
      end
      keep_in = req_valid_mask;
      if (found) begin
         keep_in[hi_idx] = 1'b0;
         keep_in[lo_idx] = 1'b0;
      end
   end

   logic [1:0]                    ch_a_ff;
   logic signed [VALUE_WIDTH-1:0] samp_a_ff [WINDOW];
   logic [WINDOW-1:0]             keep_a_ff;

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         ch_a_ff   <= req_channel;
         samp_a_ff <= samp;
         keep_a_ff <= keep_in;
      end
   end

   // stage b: sum and count of surviving samples
   logic signed [SUM_W-1:0] sum_in;
   logic [2:0]              count_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WINDOW; k++) begin
         if (keep_a_ff[k]) sum_in = sum_in + SUM_W'(samp_a_ff[k]);
      end
      // four survive only when every good sample is equal
      count_in = 3'($countones(keep_a_ff));
   end

   logic [1:0]              ch_b_ff;
   logic signed [SUM_W-1:0] sum_b_ff;
   logic [2:0]              count_b_ff;

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         ch_b_ff    <= ch_a_ff;
         sum_b_ff   <= sum_in;
         count_b_ff <= count_in;
      end
   end

   // stage c: magnitude and reciprocal multiply for the divide by three
   logic [SUM_W-1:0]  mag_full;
   logic [MAG_W-1:0]  mag_in;
   logic [PROD_W-1:0] prod_in;
   logic              neg_in;

   always_comb begin
      neg_in   = sum_b_ff[SUM_W-1];
      mag_full = neg_in ? SUM_W'(-sum_b_ff) : SUM_W'(sum_b_ff);
      mag_in   = mag_full[MAG_W-1:0];
      prod_in  = PROD_W'(mag_in) * PROD_W'(RECIP);
   end

   logic [1:0]        ch_c_ff;
   logic [2:0]        count_c_ff;
   logic [SUM_W-1:0]  mag_c_ff;
   logic [PROD_W-1:0] prod_c_ff;
   logic              neg_c_ff;

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         ch_c_ff    <= ch_b_ff;
         count_c_ff <= count_b_ff;
         mag_c_ff   <= mag_full;
         prod_c_ff  <= prod_in;
         neg_c_ff   <= neg_in;
      end
   end

   // stage d: quotient correction, select by count, restore sign
   logic [MAG_W-1:0]       mag_lo, q0, q3, rem, quot, avg_full;
   logic signed [VALUE_WIDTH-1:0] avg_in;
   logic                   avg_valid_in;

   always_comb begin
      mag_lo = mag_c_ff[MAG_W-1:0];
      // estimate is exact or one low
      q0  = {1'b0, prod_c_ff[PROD_W-1:SHIFT]};
      rem = mag_lo - (q0 + (q0 << 1));
      q3  = (rem >= MAG_W'(3)) ? q0 + MAG_W'(1) : q0;
      case (count_c_ff)
         3'd1:    quot = mag_lo;
         3'd2:    quot = mag_lo >> 1;
         3'd3:    quot = q3;
         3'd4:    quot = {1'b0, mag_c_ff[SUM_W-1:2]};
         default: quot = '0;
      endcase
      avg_full     = neg_c_ff ? (~quot + MAG_W'(1)) : quot;
      avg_in       = avg_full[VALUE_WIDTH-1:0];
      avg_valid_in = (count_c_ff != 3'd0);
   end

   logic [1:0]                    ch_d_ff;
   logic signed [VALUE_WIDTH-1:0] avg_d_ff;
   logic                          avg_valid_d_ff;

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         ch_d_ff        <= ch_c_ff;
         avg_d_ff       <= avg_in;
         avg_valid_d_ff <= avg_valid_in;
      end
   end

   // stage e: limit compares, registered onto the result port
   logic signed [CMP_W-1:0] avg_ext;
   logic                    warn_in, crit_in;

   always_comb begin
      avg_ext = CMP_W'(avg_d_ff);
      warn_in = 1'b0;
      crit_in = 1'b0;
      case (ch_d_ff)
         CH_TEMP: begin
            warn_in = avg_ext < lim_ext(limit_ff[REG_TEMP_WARN][LIMIT_WIDTH-1:0])
                   || avg_ext > lim_ext(limit_ff[REG_TEMP_WARN][REG_WIDTH-1:LIMIT_WIDTH]);
            crit_in = avg_ext < lim_ext(limit_ff[REG_TEMP_CRIT][LIMIT_WIDTH-1:0])
                   || avg_ext > lim_ext(limit_ff[REG_TEMP_CRIT][REG_WIDTH-1:LIMIT_WIDTH]);
         end
         CH_HUMID: begin
            warn_in = avg_ext < lim_ext(limit_ff[REG_HUMID_WARN][LIMIT_WIDTH-1:0])
                   || avg_ext > lim_ext(limit_ff[REG_HUMID_WARN][REG_WIDTH-1:LIMIT_WIDTH]);
            crit_in = avg_ext < lim_ext(limit_ff[REG_HUMID_CRIT][LIMIT_WIDTH-1:0])
                   || avg_ext > lim_ext(limit_ff[REG_HUMID_CRIT][REG_WIDTH-1:LIMIT_WIDTH]);
         end
         CH_LIGHT: begin
            warn_in = avg_ext < lim_ext(limit_ff[REG_LIGHT][LIMIT_WIDTH-1:0]);
            crit_in = avg_ext < lim_ext(limit_ff[REG_LIGHT][REG_WIDTH-1:LIMIT_WIDTH]);
         end
         CH_GAS: begin
            warn_in = avg_ext > lim_ext(limit_ff[REG_GAS][LIMIT_WIDTH-1:0]);
            crit_in = avg_ext > lim_ext(limit_ff[REG_GAS][REG_WIDTH-1:LIMIT_WIDTH]);
         end
         default: begin
            warn_in = 1'b0;
            crit_in = 1'b0;
         end
      endcase
      if (!avg_valid_d_ff) begin
         warn_in = 1'b0;
         crit_in = 1'b0;
      end
   end

   logic [1:0]                    ch_e_ff;
   logic signed [VALUE_WIDTH-1:0] avg_e_ff;
   logic                          avg_valid_e_ff, warn_e_ff, crit_e_ff;

   always_ff @(posedge clock) begin
      if (rdy_e) begin
         ch_e_ff        <= ch_d_ff;
         avg_e_ff       <= avg_d_ff;
         avg_valid_e_ff <= avg_valid_d_ff;
         warn_e_ff      <= warn_in;
         crit_e_ff      <= crit_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = ch_e_ff;
   assign rsp_average       = avg_e_ff;
   assign rsp_average_valid = avg_valid_e_ff;
   assign rsp_warn          = warn_e_ff;
   assign rsp_crit          = crit_e_ff;

   // an empty result carries zero average and no alarms
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_valid |-> rsp_average == '0 && !rsp_warn && !rsp_crit)
      else $error("empty window result not cleared");

   // an accepted item always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_a_ff)
      else $error("accepted item lost at first stage");

   // a free first stage never refuses an item
   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !v_a_ff |-> req_ready)
      else $error("input stalled with first stage empty");

endmodule

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import twma_pkg::*;

   localparam int VW              = VALUE_WIDTH_DEF;
   localparam int SAMPLE_MAX      = 2 ** (VW - 1) - 1;
   localparam int SAMPLE_MIN      = -(2 ** (VW - 1));
   localparam int LIMIT_MAX       = 2 ** (LIMIT_WIDTH - 1) - 1;
   localparam int LIMIT_MIN       = -(2 ** (LIMIT_WIDTH - 1));
   localparam int CYCLE_LIMIT     = 300000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int DRAIN_CYCLES    = 20;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_COUNT  = 25;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [1:0]           channel;
      logic signed [VW-1:0] s0;
      logic signed [VW-1:0] s1;
      logic signed [VW-1:0] s2;
      logic signed [VW-1:0] s3;
      logic signed [VW-1:0] s4;
      logic [WINDOW-1:0]    mask;
   } window_type;

   typedef struct packed {
      logic [1:0]           channel;
      logic signed [VW-1:0] average;
      logic                 avg_ok;
      logic                 warn;
      logic                 crit;
   } verdict_type;

   typedef struct packed {
      bit          fixed;
      window_type  win;
      verdict_type want;
   } vector_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_channel;
   logic signed [VW-1:0] req_sample_0;
   logic signed [VW-1:0] req_sample_1;
   logic signed [VW-1:0] req_sample_2;
   logic signed [VW-1:0] req_sample_3;
   logic signed [VW-1:0] req_sample_4;
   logic [WINDOW-1:0]    req_valid_mask;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_out_channel;
   logic signed [VW-1:0] rsp_average;
   logic                 rsp_average_valid;
   logic                 rsp_warn;
   logic                 rsp_crit;
   logic                 csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   limit_reg_type        csr_wdata;

   limit_reg_type limits_model [REG_COUNT] = REG_RESET;
   verdict_type   verdict_q [$];
   verdict_type   seen;
   verdict_type   want;
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            idle_on = 1'b1;
   int            idle_pct = 20;

   vector_type directed_vec [DIRECTED_COUNT] = '{
      // empty mask, then a lone sample that is both max and min
      '{1'b1, '{CH_TEMP, 0, 0, 0, 0, 0, 5'b00000}, '{CH_TEMP, 0, 1'b0, 1'b0, 1'b0}},
      '{1'b1, '{CH_HUMID, 4000, 0, 0, 0, 0, 5'b00001}, '{CH_HUMID, 0, 1'b0, 1'b0, 1'b0}},
      '{1'b1, '{CH_GAS, 524287, 524287, 524287, 524287, 524287, 5'b11111},
              '{CH_GAS, 524287, 1'b1, 1'b1, 1'b1}},
      '{1'b1, '{CH_LIGHT, -524288, -524288, -524288, -524288, -524288, 5'b11111},
              '{CH_LIGHT, -524288, 1'b1, 1'b1, 1'b1}},
      '{1'b1, '{CH_TEMP, 2000, 2100, 2200, 2300, 2400, 5'b11111},
              '{CH_TEMP, 2200, 1'b1, 1'b0, 1'b0}},
      '{1'b1, '{CH_GAS, 1500, 1500, 0, 0, 0, 5'b00011}, '{CH_GAS, 1500, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{CH_LIGHT, 300, 300, 300, 300, 300, 5'b11111},
              '{CH_LIGHT, 300, 1'b1, 1'b0, 1'b0}},
      // limit edges under the reset limits
      '{1'b0, '{CH_LIGHT, 299, 299, 299, 299, 299, 5'b11111}, '0},
      '{1'b0, '{CH_LIGHT, 99, 99, 99, 99, 99, 5'b11111}, '0},
      '{1'b0, '{CH_TEMP, 1799, 1799, 1799, 1799, 1799, 5'b11111}, '0},
      '{1'b0, '{CH_TEMP, 1800, 1800, 1800, 1800, 1800, 5'b00111}, '0},
      '{1'b0, '{CH_TEMP, 2600, 2600, 2600, 2600, 2600, 5'b11100}, '0},
      '{1'b0, '{CH_TEMP, 2601, 2601, 2601, 2601, 2601, 5'b11111}, '0},
      '{1'b0, '{CH_TEMP, 3501, 3501, 3501, 3501, 3501, 5'b11111}, '0},
      '{1'b0, '{CH_HUMID, 2999, 2999, 2999, 2999, 2999, 5'b11111}, '0},
      '{1'b0, '{CH_HUMID, 6001, 6001, 6001, 6001, 6001, 5'b11111}, '0},
      '{1'b0, '{CH_HUMID, 8001, 8001, 8001, 8001, 8001, 5'b11111}, '0},
      '{1'b0, '{CH_GAS, 1001, 1001, 1001, 1001, 1001, 5'b11111}, '0},
      '{1'b0, '{CH_GAS, 2001, 2001, 2001, 2001, 2001, 5'b11111}, '0},
      // negative sum truncates toward zero
      '{1'b0, '{CH_HUMID, -7, -3, 100, -200, 4, 5'b11111}, '0},
      '{1'b0, '{CH_TEMP, 524287, -524288, 524287, -524288, 0, 5'b11111}, '0},
      // repeated max and min, lowest index is dropped
      '{1'b0, '{CH_GAS, 3, 9, 9, 1, 1, 5'b11111}, '0},
      '{1'b0, '{CH_LIGHT, -10, 5, -10, 5, -3, 5'b01111}, '0},
      '{1'b0, '{CH_TEMP, 349525, -349526, 349525, -349526, 349525, 5'b10101}, '0},
      '{1'b0, '{CH_HUMID, 100, 1, 2, 3, 4, 5'b11110}, '0}
   };

   trimmed_mean_window_alarm #(
      .VALUE_WIDTH (VW)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel       (req_channel),
      .req_sample_0      (req_sample_0),
      .req_sample_1      (req_sample_1),
      .req_sample_2      (req_sample_2),
      .req_sample_3      (req_sample_3),
      .req_sample_4      (req_sample_4),
      .req_valid_mask    (req_valid_mask),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_average       (rsp_average),
      .rsp_average_valid (rsp_average_valid),
      .rsp_warn          (rsp_warn),
      .rsp_crit          (rsp_crit),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic longint limit_field(limit_reg_type r, bit upper);
      logic [LIMIT_WIDTH-1:0] f;
      f = upper ? r[REG_WIDTH-1:LIMIT_WIDTH] : r[LIMIT_WIDTH-1:0];
      return longint'($signed(f));
   endfunction

   function automatic bit outside_window(longint x, limit_reg_type r);
      return x < limit_field(r, 1'b0) || x > limit_field(r, 1'b1);
   endfunction

   function automatic limit_reg_type pack_limits(int lo, int hi);
      return {LIMIT_WIDTH'(hi), LIMIT_WIDTH'(lo)};
   endfunction

   function automatic verdict_type predict_trimmed(window_type w);
      longint      v [WINDOW];
      int          hi_k;
      int          lo_k;
      int          cnt;
      longint      total;
      longint      mean;
      verdict_type r;
      v[0] = longint'($signed(w.s0));
      v[1] = longint'($signed(w.s1));
      v[2] = longint'($signed(w.s2));
      v[3] = longint'($signed(w.s3));
      v[4] = longint'($signed(w.s4));
      hi_k = -1;
      lo_k = -1;
      for (int k = 0; k < WINDOW; k++) begin
         if (w.mask[k]) begin
            if (hi_k < 0 || v[k] > v[hi_k]) hi_k = k;
            if (lo_k < 0 || v[k] < v[lo_k]) lo_k = k;
         end
      end
      total = 0;
      cnt = 0;
      for (int k = 0; k < WINDOW; k++) begin
         if (w.mask[k] && k != hi_k && k != lo_k) begin
            total += v[k];
            cnt++;
         end
      end
      r = '0;
      r.channel = w.channel;
      if (cnt != 0) begin
         mean = total / cnt;
         r.average = VW'(mean);
         r.avg_ok = 1'b1;
         case (w.channel)
            CH_TEMP: begin
               r.warn = outside_window(mean, limits_model[REG_TEMP_WARN]);
               r.crit = outside_window(mean, limits_model[REG_TEMP_CRIT]);
            end
            CH_HUMID: begin
               r.warn = outside_window(mean, limits_model[REG_HUMID_WARN]);
               r.crit = outside_window(mean, limits_model[REG_HUMID_CRIT]);
            end
            CH_LIGHT: begin
               r.warn = mean < limit_field(limits_model[REG_LIGHT], 1'b0);
               r.crit = mean < limit_field(limits_model[REG_LIGHT], 1'b1);
            end
            default: begin
               r.warn = mean > limit_field(limits_model[REG_GAS], 1'b0);
               r.crit = mean > limit_field(limits_model[REG_GAS], 1'b1);
            end
         endcase
      end
      return r;
   endfunction

   // mostly values around the alarm limits, some full range, repeats for ties
   function automatic logic signed [VW-1:0] random_sample(logic signed [VW-1:0] prev);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return VW'(int'($urandom_range(0, 13000)) - 3000);
      if (roll < 75) return VW'($urandom);
      if (roll < 88) return prev;
      case ($urandom_range(0, 3))
         0: return VW'(SAMPLE_MAX);
         1: return VW'(SAMPLE_MIN);
         2: return '1;
         default: return '0;
      endcase
   endfunction

   function automatic window_type random_window();
      window_type w;
      int         roll;
      w.channel = 2'($urandom);
      w.s0 = random_sample(VW'($urandom));
      w.s1 = random_sample(w.s0);
      w.s2 = random_sample(w.s1);
      w.s3 = random_sample(w.s2);
      w.s4 = random_sample(w.s3);
      roll = $urandom_range(0, 9);
      if (roll < 5) w.mask = '1;
      else if (roll < 8) w.mask = WINDOW'($urandom);
      else w.mask = WINDOW'($urandom & $urandom);
      return w;
   endfunction

   function automatic limit_reg_type random_limits();
      return pack_limits(int'($urandom_range(0, 13000)) - 3000,
                         int'($urandom_range(0, 13000)) - 3000);
   endfunction

   task automatic write_limit(logic [CSR_INDEX_W-1:0] idx, limit_reg_type val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      if (idx < REG_COUNT) limits_model[idx] = val;
   endtask

   task automatic program_limits(limit_reg_type tw, limit_reg_type tc, limit_reg_type hw,
                                 limit_reg_type hc, limit_reg_type lt, limit_reg_type gs);
      write_limit(REG_TEMP_WARN, tw);
      write_limit(REG_TEMP_CRIT, tc);
      write_limit(REG_HUMID_WARN, hw);
      write_limit(REG_HUMID_CRIT, hc);
      write_limit(REG_LIGHT, lt);
      write_limit(REG_GAS, gs);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   // valid is left high after acceptance; it is lowered here for random idle gaps and by the caller before draining
   task automatic send_item(window_type w, bit fixed, verdict_type typed);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_channel    <= w.channel;
      req_sample_0   <= w.s0;
      req_sample_1   <= w.s1;
      req_sample_2   <= w.s2;
      req_sample_3   <= w.s3;
      req_sample_4   <= w.s4;
      req_valid_mask <= w.mask;
      do @(posedge clock); while (!req_ready);
      verdict_q.push_back(fixed ? typed : predict_trimmed(w));
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("trimmed_mean_window_alarm: mismatch");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && !reset && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_out_channel, rsp_average, rsp_average_valid, rsp_warn, rsp_crit};
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected item: ch %0d avg %0d ok %0b warn %0b crit %0b",
                        seen.channel, $signed(seen.average), seen.avg_ok, seen.warn,
                        seen.crit);
         end else begin
            want = verdict_q.pop_front();
            if (seen.channel !== want.channel || seen.average !== want.average ||
                seen.avg_ok !== want.avg_ok || seen.warn !== want.warn ||
                seen.crit !== want.crit) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"expected ch %0d avg %0d ok %0b warn %0b crit %0b, ",
                            "got ch %0d avg %0d ok %0b warn %0b crit %0b"},
                           want.channel, $signed(want.average), want.avg_ok, want.warn,
                           want.crit, seen.channel, $signed(seen.average), seen.avg_ok,
                           seen.warn, seen.crit);
            end
         end
      end
   end

   initial begin
      int            ph;
      int            n;
      limit_reg_type val;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_channel    = CH_TEMP;
      req_sample_0   = '0;
      req_sample_1   = '0;
      req_sample_2   = '0;
      req_sample_3   = '0;
      req_sample_4   = '0;
      req_valid_mask = '0;
      csr_write_en   = 1'b0;
      csr_index      = REG_TEMP_WARN;
      csr_wdata      = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_vec[i])
         send_item(directed_vec[i].win, directed_vec[i].fixed, directed_vec[i].want);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();
         case (ph)
            1: program_limits('0, '0, '0, '0, '0, '0);
            2: program_limits('1, '1, '1, '1, '1, '1);
            3: begin
               val = pack_limits(LIMIT_MIN, LIMIT_MAX);
               program_limits(val, val, val, val, val, val);
            end
            4: begin
               // bounds in the wrong order
               val = pack_limits(LIMIT_MAX, LIMIT_MIN);
               program_limits(val, val, val, val, val, val);
            end
            5, 6, 7: begin
               if (ph == 5) begin
                  write_limit(REG_SPARE_6, limit_reg_type'({$urandom, $urandom}));
                  write_limit(REG_SPARE_7, limit_reg_type'({$urandom, $urandom}));
               end
               program_limits(random_limits(), random_limits(), random_limits(),
                              random_limits(), random_limits(), random_limits());
            end
            default: ;
         endcase
         idle_on  = (ph != RANDOM_PHASES - 1);
         idle_pct = $urandom_range(5, 40);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               @(negedge clock);
               req_valid <= 1'b0;
               wait_drained();
            end
            send_item(random_window(), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0)
         $display("trimmed_mean_window_alarm: match");
      else
         $display("trimmed_mean_window_alarm: mismatch");
      $finish;
   end

endmodule
